[rtl/core/lms_coefficient_update_defines.svh]
// assertion macros for the lms coefficient update block
`ifndef LMS_COEFFICIENT_UPDATE_DEFINES_SVH
`define LMS_COEFFICIENT_UPDATE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define LMS_CU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lms_coefficient_update check failed");

// next-cycle implication, checked while out of reset
`define LMS_CU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lms_coefficient_update check failed");

`endif

[rtl/core/lms_cu_pkg.sv]
`default_nettype none
package lms_cu_pkg;

  localparam int MAX_TAPS = 32;
  localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;
  localparam int DATA_W   = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_TAPS = 2'd2;

  localparam logic [5:0] TAPS_RESET = 6'd32;

  // rounding terms and shifts of the correction
  localparam logic signed [31:0] RND_PRE    = 32'sh10;
  localparam int                 SH_PRE     = 5;
  localparam logic [33:0]        RND_TWO    = 34'h10000;
  localparam int                 SH_TWO     = 17;
  localparam logic [33:0]        RND_SINGLE = 34'h20000;
  localparam int                 SH_SINGLE  = 18;

  typedef enum logic [1:0] {
    FUNC_WR_HIST = 2'd0,
    FUNC_WR_COEF = 2'd1,
    FUNC_UPDATE  = 2'd2,
    FUNC_RD_COEF = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_UPD,
    KIND_READ,
    KIND_REFUSE
  } kind_e;

  typedef struct packed {
    func_e              func;
    logic [4:0]         address;
    logic signed [15:0] write_value;
    logic signed [15:0] error_value;
    logic [4:0]         newest_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [4:0]         tap_index;
    logic               last;
    logic               refused;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             hist_we;
    logic             coef_we;
    logic             issue;
    kind_e            kind;
    logic [TAP_W-1:0] tap;
    logic [TAP_W-1:0] hidx;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic             pipe_empty;
    logic             adv;
    func_e            func;
    logic [4:0]       newest;
    logic [CNT_W-1:0] taps_eff;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/lms_cu_ram.sv]
`default_nettype none
module lms_cu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/lms_cu_ctrl.sv]
`default_nettype none
module lms_cu_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lms_cu_pkg::dp_stat_t stat_i,
  output lms_cu_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN
  } state_e;

  state_e                       state_q, state_d;
  logic [lms_cu_pkg::TAP_W-1:0] n_q, n_d;
  logic [lms_cu_pkg::TAP_W-1:0] hidx_q, hidx_d;
  logic [lms_cu_pkg::TAP_W-1:0] last_tap;
  logic                         refuse;

  always_comb begin
    last_tap = lms_cu_pkg::TAP_W'(stat_i.taps_eff - lms_cu_pkg::CNT_W'(1));
    refuse   = lms_cu_pkg::CMP_W'(stat_i.newest) >= lms_cu_pkg::CMP_W'(stat_i.taps_eff);
    in_ready_o = (state_q == ST_IDLE) && stat_i.pipe_empty;

    cmd_o      = '0;
    cmd_o.kind = lms_cu_pkg::KIND_UPD;
    cmd_o.tap  = n_q;
    cmd_o.hidx = hidx_q;
    state_d    = state_q;
    n_d        = n_q;
    hidx_d     = hidx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat_i.func)
          lms_cu_pkg::FUNC_WR_HIST: begin
            cmd_o.hist_we = 1'b1;
            state_d       = ST_IDLE;
          end
          lms_cu_pkg::FUNC_WR_COEF: begin
            cmd_o.coef_we = 1'b1;
            state_d       = ST_IDLE;
          end
          lms_cu_pkg::FUNC_RD_COEF: begin
            cmd_o.issue = 1'b1;
            cmd_o.kind  = lms_cu_pkg::KIND_READ;
            cmd_o.last  = 1'b1;
            if (stat_i.adv) begin
              state_d = ST_IDLE;
            end
          end
          lms_cu_pkg::FUNC_UPDATE: begin
            if (refuse) begin
              cmd_o.issue = 1'b1;
              cmd_o.kind  = lms_cu_pkg::KIND_REFUSE;
              cmd_o.last  = 1'b1;
              if (stat_i.adv) begin
                state_d = ST_IDLE;
              end
            end else begin
              n_d     = '0;
              hidx_d  = lms_cu_pkg::TAP_W'(stat_i.newest);
              state_d = ST_RUN;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        cmd_o.last  = (n_q == last_tap);
        if (stat_i.adv) begin
          if (n_q == last_tap) begin
            state_d = ST_IDLE;
          end else begin
            n_d    = n_q + lms_cu_pkg::TAP_W'(1);
            hidx_d = (hidx_q == '0) ? last_tap : hidx_q - lms_cu_pkg::TAP_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      hidx_q  <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      hidx_q  <= hidx_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/lms_cu_dp.sv]
`default_nettype none
module lms_cu_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire lms_cu_pkg::in_item_t                in_item_i,
  input  wire lms_cu_pkg::dp_cmd_t                 cmd_i,
  output lms_cu_pkg::dp_stat_t                     stat_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output lms_cu_pkg::out_item_t                    out_item_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lms_cu_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [lms_cu_pkg::PDATA_W-1:0]      pwdata,
  output logic      [lms_cu_pkg::PDATA_W-1:0]      prdata,
  output logic                                     pready
);

  localparam int TW = lms_cu_pkg::TAP_W;
  localparam int DW = lms_cu_pkg::DATA_W;

  lms_cu_pkg::in_item_t  item_q;
  logic                  mode_q;
  logic signed [DW-1:0]  step_q;
  logic [5:0]            taps_q;

  logic [1:0]            cfg_idx;
  logic                  cfg_we;
  logic [lms_cu_pkg::CNT_W-1:0] taps_eff;
  logic                  addr_ok;
  logic [TW-1:0]         addr_t;
  logic                  adv;
  logic                  re;

  logic [lms_cu_pkg::MAX_TAPS-1:0] cvld_q, hvld_q;

  logic                  wb_we, coef_we, hist_we;
  logic [TW-1:0]         coef_waddr, coef_raddr;
  logic [DW-1:0]         coef_wdata;
  logic [DW-1:0]         coef_rd, hist_rd;

  // read stage
  logic                  s1_v_q;
  lms_cu_pkg::kind_e     s1_kind_q;
  logic [TW-1:0]         s1_n_q;
  logic [4:0]            s1_tap_q;
  logic                  s1_last_q, s1_cok_q, s1_hok_q;
  // first product stage
  logic                  s2_v_q;
  lms_cu_pkg::kind_e     s2_kind_q;
  logic [TW-1:0]         s2_n_q;
  logic [4:0]            s2_tap_q;
  logic                  s2_last_q;
  logic signed [DW-1:0]  s2_coef_q;
  logic signed [31:0]    p1_q;
  // second product stage
  logic                  s3_v_q;
  lms_cu_pkg::kind_e     s3_kind_q;
  logic [TW-1:0]         s3_n_q;
  logic [4:0]            s3_tap_q;
  logic                  s3_last_q;
  logic signed [DW-1:0]  s3_coef_q;
  logic signed [31:0]    p2_q;
  // output register
  logic                  out_v_q;
  lms_cu_pkg::out_item_t out_item_q, out_item_d;

  logic signed [DW-1:0]  h_val, mult, t_val;
  logic signed [31:0]    prod1, prod2, pre_sum;
  logic [33:0]           rnd_sum;
  logic [DW-1:0]         corr, new_coef;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[lms_cu_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      step_q <= '0;
      taps_q <= lms_cu_pkg::TAPS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        lms_cu_pkg::REG_MODE: mode_q <= pwdata[0];
        lms_cu_pkg::REG_STEP: step_q <= pwdata[DW-1:0];
        lms_cu_pkg::REG_TAPS: taps_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lms_cu_pkg::REG_MODE: prdata = lms_cu_pkg::PDATA_W'(mode_q);
      lms_cu_pkg::REG_STEP: prdata = lms_cu_pkg::PDATA_W'(unsigned'(step_q));
      lms_cu_pkg::REG_TAPS: prdata = lms_cu_pkg::PDATA_W'(taps_q);
      default:              prdata = '0;
    endcase
  end

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
  end

  assign taps_eff = (int'(taps_q) > lms_cu_pkg::MAX_TAPS) ?
                    lms_cu_pkg::CNT_W'(lms_cu_pkg::MAX_TAPS) : lms_cu_pkg::CNT_W'(taps_q);
  assign addr_ok  = int'(item_q.address) < lms_cu_pkg::MAX_TAPS;
  assign addr_t   = TW'(item_q.address);
  assign adv      = !out_v_q || out_ready_i;
  assign re       = cmd_i.issue && adv;

  assign stat_o.pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q;
  assign stat_o.adv        = adv;
  assign stat_o.func       = item_q.func;
  assign stat_o.newest     = item_q.newest_index;
  assign stat_o.taps_eff   = taps_eff;

  // store access
  assign wb_we      = adv && s3_v_q && (s3_kind_q == lms_cu_pkg::KIND_UPD);
  assign coef_we    = wb_we || (cmd_i.coef_we && addr_ok);
  assign coef_waddr = wb_we ? s3_n_q : addr_t;
  assign coef_wdata = wb_we ? new_coef : item_q.write_value;
  assign coef_raddr = (cmd_i.kind == lms_cu_pkg::KIND_READ) ? addr_t : cmd_i.tap;
  assign hist_we    = cmd_i.hist_we && addr_ok;

  lms_cu_ram #(.WIDTH(DW), .DEPTH(lms_cu_pkg::MAX_TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .re_i    (re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rd)
  );

  lms_cu_ram #(.WIDTH(DW), .DEPTH(lms_cu_pkg::MAX_TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (addr_t),
    .wdata_i (item_q.write_value),
    .re_i    (re),
    .raddr_i (cmd_i.hidx),
    .rdata_o (hist_rd)
  );

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= '0;
      hvld_q <= '0;
    end else begin
      if (coef_we) begin
        cvld_q[coef_waddr] <= 1'b1;
      end
      if (hist_we) begin
        hvld_q[addr_t] <= 1'b1;
      end
    end
  end

  // arithmetic
  always_comb begin
    h_val    = s1_hok_q ? signed'(hist_rd) : '0;
    mult     = mode_q ? step_q : item_q.error_value;
    prod1    = h_val * mult;
    pre_sum  = p1_q + lms_cu_pkg::RND_PRE;
    t_val    = pre_sum[lms_cu_pkg::SH_PRE+DW-1:lms_cu_pkg::SH_PRE];
    prod2    = t_val * item_q.error_value;
    rnd_sum  = {{2{p2_q[31]}}, p2_q} + (mode_q ? lms_cu_pkg::RND_TWO : lms_cu_pkg::RND_SINGLE);
    corr     = mode_q ? rnd_sum[lms_cu_pkg::SH_TWO+DW-1:lms_cu_pkg::SH_TWO]
                      : rnd_sum[lms_cu_pkg::SH_SINGLE+DW-1:lms_cu_pkg::SH_SINGLE];
    new_coef = s3_coef_q + corr;
  end

  always_comb begin
    out_item_d = '0;
    case (s3_kind_q)
      lms_cu_pkg::KIND_UPD: begin
        out_item_d.coefficient = new_coef;
        out_item_d.tap_index   = s3_tap_q;
        out_item_d.last        = s3_last_q;
      end
      lms_cu_pkg::KIND_READ: begin
        out_item_d.coefficient = s3_coef_q;
        out_item_d.tap_index   = s3_tap_q;
        out_item_d.last        = s3_last_q;
      end
      lms_cu_pkg::KIND_REFUSE: begin
        out_item_d.last    = 1'b1;
        out_item_d.refused = 1'b1;
      end
      default: out_item_d = '0;
    endcase
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= cmd_i.issue;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (re) begin
      s1_kind_q <= cmd_i.kind;
      s1_n_q    <= cmd_i.tap;
      s1_last_q <= cmd_i.last;
      s1_hok_q  <= hvld_q[cmd_i.hidx];
      case (cmd_i.kind)
        lms_cu_pkg::KIND_READ: begin
          s1_tap_q <= item_q.address;
          s1_cok_q <= addr_ok && cvld_q[coef_raddr];
        end
        lms_cu_pkg::KIND_UPD: begin
          s1_tap_q <= 5'(cmd_i.tap);
          s1_cok_q <= cvld_q[coef_raddr];
        end
        default: begin
          s1_tap_q <= '0;
          s1_cok_q <= 1'b0;
        end
      endcase
    end
    if (adv && s1_v_q) begin
      s2_kind_q <= s1_kind_q;
      s2_n_q    <= s1_n_q;
      s2_tap_q  <= s1_tap_q;
      s2_last_q <= s1_last_q;
      s2_coef_q <= s1_cok_q ? signed'(coef_rd) : '0;
      p1_q      <= prod1;
    end
    if (adv && s2_v_q) begin
      s3_kind_q <= s2_kind_q;
      s3_n_q    <= s2_n_q;
      s3_tap_q  <= s2_tap_q;
      s3_last_q <= s2_last_q;
      s3_coef_q <= s2_coef_q;
      p2_q      <= mode_q ? prod2 : p1_q;
    end
    if (adv && s3_v_q) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

[rtl/core/lms_coefficient_update.sv]
// update item: T taps (refused if newest index >= T); the next item waits for the
//   read and product stages to drain; one result per cycle unless the output stalls
//   (one tap per cycle through the coefficient memory and the multiply stages)
// read item: one result; write items give no result
// reset: asynchronous, clears control, restores registers, both stores read as zero
`default_nettype none
module lms_coefficient_update (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire lms_cu_pkg::in_item_t           in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output lms_cu_pkg::out_item_t               out_item_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lms_cu_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lms_cu_pkg::PDATA_W-1:0] pwdata,
  output logic      [lms_cu_pkg::PDATA_W-1:0] prdata,
  output logic                                pready
);

  lms_cu_pkg::dp_cmd_t  cmd;
  lms_cu_pkg::dp_stat_t stat;

  lms_cu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lms_cu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

endmodule
`default_nettype wire

[rtl/core/lms_cu_checker.sv]
`default_nettype none
`include "lms_coefficient_update_defines.svh"
module lms_cu_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire lms_cu_pkg::out_item_t out_item_i
);

  logic refused_seen;
  logic refused_ok;

  assign refused_seen = out_valid_i && out_item_i.refused;
  assign refused_ok   = out_item_i.last && (out_item_i.coefficient == '0) &&
                        (out_item_i.tap_index == '0);

  `LMS_CU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `LMS_CU_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_item_i))
  `LMS_CU_ASSERT_NEXT(a_no_back_to_back, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `LMS_CU_ASSERT_SAME(a_refused_form, clk_i, rst_ni, refused_seen, refused_ok)

endmodule

bind lms_coefficient_update lms_cu_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);
`default_nettype wire
